### design/rkl_pkg.sv
// shared types, constants and register map for the reactive key backlight renderer
// no dependencies
package rkl_pkg;

  localparam int LED_NUM_DEF  = 32;
  localparam int NUMLOCK_POS  = 0;
  localparam int FADE_TIME_MS = 1000;
  localparam int MAX_EMIT     = 32;
  localparam int QUEUE_DEPTH  = 2;

  // fade divide: x / FADE_TIME_MS as (x * FADE_RECIP) >> RECIP_SH plus one correction
  localparam int          RECIP_SH   = 23;
  localparam logic [23:0] FADE_RECIP = 24'((1 << RECIP_SH) / FADE_TIME_MS);
  localparam logic [15:0] FADE_LEN   = 16'(FADE_TIME_MS);

  // exact divide by 100 for products up to 255 * 100
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SH  = 19;

  localparam logic [6:0] PCT_MAX = 7'd100;

  localparam logic [2:0] REG_EFFECT_MODE = 3'd0;
  localparam logic [2:0] REG_COLOR_RED   = 3'd1;
  localparam logic [2:0] REG_COLOR_GREEN = 3'd2;
  localparam logic [2:0] REG_COLOR_BLUE  = 3'd3;
  localparam logic [2:0] REG_NORMAL_PCT  = 3'd4;
  localparam logic [2:0] REG_NUMLOCK_PCT = 3'd5;
  localparam logic [2:0] REG_SHUTDOWN    = 3'd6;
  localparam logic [2:0] REG_PIXEL_COUNT = 3'd7;

  localparam logic [1:0] EFFECT_OFF    = 2'd0;
  localparam logic [1:0] EFFECT_STATIC = 2'd1;
  localparam logic [1:0] EFFECT_REACT  = 2'd2;
  localparam logic [1:0] EFFECT_RSVD   = 2'd3;

  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_RENDER  = 2'd2,
    MODE_POLL    = 2'd3
  } in_mode_t;

  typedef struct packed {
    logic [1:0] effect;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] norm_pct;
    logic [6:0] nl_pct;
    logic       shutdown;
    logic [5:0] count;
  } cfg_t;

  typedef struct packed {
    in_mode_t    op;
    logic [4:0]  key;
    logic [31:0] now;
    logic        lock_led;
  } item_t;

endpackage

### design/rkl_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module rkl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/rkl_regs.sv
// apb configuration registers with clamped views for the render engine
// depends on rkl_pkg
module rkl_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rkl_pkg::cfg_t       cfg
);

  logic [1:0] effect_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic [6:0] norm_r;
  logic [6:0] nl_r;
  logic       shut_r;
  logic [5:0] count_r;
  logic       wr;
  logic [2:0] sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_r <= rkl_pkg::EFFECT_REACT;
      red_r    <= 8'd255;
      green_r  <= 8'd0;
      blue_r   <= 8'd0;
      norm_r   <= rkl_pkg::PCT_MAX;
      nl_r     <= rkl_pkg::PCT_MAX;
      shut_r   <= 1'b0;
      count_r  <= 6'(rkl_pkg::MAX_EMIT);
    end else if (wr) begin
      case (sel)
        rkl_pkg::REG_EFFECT_MODE: effect_r <= pwdata[1:0];
        rkl_pkg::REG_COLOR_RED:   red_r    <= pwdata[7:0];
        rkl_pkg::REG_COLOR_GREEN: green_r  <= pwdata[7:0];
        rkl_pkg::REG_COLOR_BLUE:  blue_r   <= pwdata[7:0];
        rkl_pkg::REG_NORMAL_PCT:  norm_r   <= pwdata[6:0];
        rkl_pkg::REG_NUMLOCK_PCT: nl_r     <= pwdata[6:0];
        rkl_pkg::REG_SHUTDOWN:    shut_r   <= pwdata[0];
        rkl_pkg::REG_PIXEL_COUNT: count_r  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      rkl_pkg::REG_EFFECT_MODE: prdata = {30'd0, effect_r};
      rkl_pkg::REG_COLOR_RED:   prdata = {24'd0, red_r};
      rkl_pkg::REG_COLOR_GREEN: prdata = {24'd0, green_r};
      rkl_pkg::REG_COLOR_BLUE:  prdata = {24'd0, blue_r};
      rkl_pkg::REG_NORMAL_PCT:  prdata = {25'd0, norm_r};
      rkl_pkg::REG_NUMLOCK_PCT: prdata = {25'd0, nl_r};
      rkl_pkg::REG_SHUTDOWN:    prdata = {31'd0, shut_r};
      rkl_pkg::REG_PIXEL_COUNT: prdata = {26'd0, count_r};
      default:                  prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.effect   = effect_r;
    cfg.red      = red_r;
    cfg.green    = green_r;
    cfg.blue     = blue_r;
    cfg.norm_pct = (norm_r > rkl_pkg::PCT_MAX) ? rkl_pkg::PCT_MAX : norm_r;
    cfg.nl_pct   = (nl_r > rkl_pkg::PCT_MAX) ? rkl_pkg::PCT_MAX : nl_r;
    cfg.shutdown = shut_r;
    cfg.count    = (count_r > 6'(rkl_pkg::MAX_EMIT)) ? 6'(rkl_pkg::MAX_EMIT) : count_r;
  end

endmodule

### design/rkl_front.sv
// command front end: accepts items, drops unusable key events, queues the rest
// depends on rkl_pkg
module rkl_front #(
  parameter int LED_NUM = rkl_pkg::LED_NUM_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     in_mode,
  input  logic [4:0]     in_key_index,
  input  logic [31:0]    in_now_ms,
  input  logic           in_lock_led,
  output logic           q_valid,
  output rkl_pkg::item_t q_item,
  input  logic           q_pop
);

  localparam int PTR_W = $clog2(rkl_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(rkl_pkg::QUEUE_DEPTH);

  rkl_pkg::item_t   mem_r [rkl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             key_ok;
  logic             keep;
  logic             push;
  rkl_pkg::item_t   item;

  assign key_ok = (int'(in_key_index) < LED_NUM) &&
                  (int'(in_key_index) != rkl_pkg::NUMLOCK_POS);
  assign keep   = (in_mode == rkl_pkg::MODE_RENDER) || (in_mode == rkl_pkg::MODE_POLL) ||
                  key_ok;
  assign busy    = (cnt_r == FULL);
  assign push    = start && !busy && keep;
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];

  always_comb begin
    item.op       = rkl_pkg::in_mode_t'(in_mode);
    item.key      = in_key_index;
    item.now      = in_now_ms;
    item.lock_led = in_lock_led;
  end

  always_comb begin
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= PTR_W'(wp_r + 1'b1);
      end
      if (q_pop) begin
        rp_r <= PTR_W'(rp_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item;
    end
  end

endmodule

### design/rkl_back.sv
// back end: key state, release time ram, render pixel pipeline and poll scan
// depends on rkl_pkg and rkl_ram
module rkl_back #(
  parameter int LED_NUM = rkl_pkg::LED_NUM_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rkl_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  rkl_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_strobe,
  output logic [4:0]     out_pixel_index,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic           out_last,
  output logic           out_any_active
);

  localparam int IDX_W = $clog2(LED_NUM);
  localparam logic [IDX_W-1:0] SCAN_END = IDX_W'(LED_NUM - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_PEND = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_FULL = 2'd1,
    SEL_FADE = 2'd2
  } sel_t;

  typedef struct packed {
    logic       vld;
    logic [4:0] idx;
    logic       last;
    logic       ovl;
    logic       inr;
    logic       held;
    logic       fading;
    sel_t       sel;
  } pix_t;

  state_t           state_r, state_nxt;
  logic [4:0]       pix_r;
  logic [IDX_W-1:0] scan_r;
  logic [31:0]      now_r;
  logic             nl_r;
  logic             act_r;
  logic             sv_r, sheld_r, sfade_r;
  logic [LED_NUM-1:0] held_r, fading_r;

  pix_t a_r, b_r, c_r, d_r, e_r, f_r, g_r;
  pix_t a_nxt, b_nxt;
  logic [15:0] el_r;
  logic [22:0] x_c_r, x_d_r, x_e_r;
  logic [46:0] p_d_r;
  logic [6:0]  q0_e_r;
  logic [22:0] chk_e_r;
  logic [6:0]  pct_f_r;
  logic [14:0] prod_r_r, prod_g_r, prod_b_r;

  logic             out_strobe_r, out_last_r, out_act_r;
  logic [4:0]       out_idx_r;
  logic [7:0]       out_red_r, out_green_r, out_blue_r;

  logic             pipe_busy, take, ram_we, poll_fire, poll_act, hit, clear_fade;
  logic [IDX_W-1:0] k_idx, walk_idx, raddr;
  logic             w_in;
  logic [31:0]      ram_rdata, el_a, el_s;
  logic             expired;
  logic [15:0]      rem;
  logic [22:0]      x_c_nxt, chk_nxt, resid;
  logic [46:0]      p_nxt;
  logic [6:0]       q0_nxt, fade_pct, pct_react;
  logic [7:0]       col_r, col_g, col_b;
  logic [27:0]      m_r, m_g, m_b;

  // num lock pixel takes its own brightness, everything else the key brightness
  function automatic logic [6:0] f_nxt_pct(input logic ovl, input logic [6:0] nl_pct,
                                           input logic [6:0] key_pct);
    return ovl ? nl_pct : key_pct;
  endfunction

  assign pipe_busy = a_r.vld | b_r.vld | c_r.vld | d_r.vld | e_r.vld | f_r.vld | g_r.vld;
  assign take      = (state_r == ST_IDLE) && q_valid && !pipe_busy;
  assign q_pop     = take;
  assign k_idx     = IDX_W'(q_item.key);
  assign ram_we    = take && (q_item.op == rkl_pkg::MODE_RELEASE) && held_r[k_idx];
  assign w_in      = int'(pix_r) < LED_NUM;
  assign walk_idx  = IDX_W'(pix_r);
  assign raddr     = (state_r == ST_SCAN) ? scan_r : walk_idx;

  rkl_ram #(
    .WIDTH (32),
    .DEPTH (LED_NUM)
  ) u_release_time (
    .clk   (clk),
    .we    (ram_we),
    .waddr (k_idx),
    .wdata (q_item.now),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // issue stage
  always_comb begin
    a_nxt        = '0;
    a_nxt.vld    = (state_r == ST_WALK);
    a_nxt.idx    = pix_r;
    a_nxt.last   = ((6'(pix_r) + 6'd1) == cfg.count);
    a_nxt.inr    = !cfg.shutdown && (pix_r != 5'd0) && w_in;
    a_nxt.ovl    = !cfg.shutdown && nl_r && (int'(pix_r) == rkl_pkg::NUMLOCK_POS);
    a_nxt.held   = w_in ? held_r[walk_idx] : 1'b0;
    a_nxt.fading = w_in ? fading_r[walk_idx] : 1'b0;
    a_nxt.sel    = SEL_ZERO;
  end

  // elapsed time and brightness source
  assign el_a    = now_r - ram_rdata;
  assign expired = el_a >= 32'(rkl_pkg::FADE_TIME_MS);

  always_comb begin
    b_nxt = a_r;
    if (!a_r.inr) begin
      b_nxt.sel = SEL_ZERO;
    end else begin
      case (cfg.effect)
        rkl_pkg::EFFECT_STATIC: b_nxt.sel = SEL_FULL;
        rkl_pkg::EFFECT_REACT: begin
          if (a_r.held) begin
            b_nxt.sel = SEL_FULL;
          end else if (a_r.fading && !expired) begin
            b_nxt.sel = SEL_FADE;
          end else begin
            b_nxt.sel = SEL_ZERO;
          end
        end
        default: b_nxt.sel = SEL_ZERO;
      endcase
    end
  end

  assign rem     = rkl_pkg::FADE_LEN - el_r;
  assign x_c_nxt = 23'(cfg.norm_pct) * 23'(rem);
  assign p_nxt   = 47'(x_c_r) * 47'(rkl_pkg::FADE_RECIP);
  assign q0_nxt  = p_d_r[rkl_pkg::RECIP_SH+6:rkl_pkg::RECIP_SH];
  assign chk_nxt = 23'(q0_nxt) * 23'(rkl_pkg::FADE_LEN);
  assign resid   = x_e_r - chk_e_r;
  assign fade_pct = q0_e_r + 7'((resid >= 23'(rkl_pkg::FADE_LEN)) ? 1 : 0);

  always_comb begin
    case (e_r.sel)
      SEL_FULL: pct_react = cfg.norm_pct;
      SEL_FADE: pct_react = fade_pct;
      default:  pct_react = 7'd0;
    endcase
  end

  assign clear_fade = e_r.vld && e_r.inr && (cfg.effect == rkl_pkg::EFFECT_REACT) &&
                      e_r.fading && (pct_react == 7'd0);

  assign col_r = f_r.ovl ? 8'hFF : cfg.red;
  assign col_g = f_r.ovl ? 8'hFF : cfg.green;
  assign col_b = f_r.ovl ? 8'hFF : cfg.blue;

  assign m_r = 28'(prod_r_r) * 28'(rkl_pkg::DIV100_MUL);
  assign m_g = 28'(prod_g_r) * 28'(rkl_pkg::DIV100_MUL);
  assign m_b = 28'(prod_b_r) * 28'(rkl_pkg::DIV100_MUL);

  // poll scan
  assign el_s = now_r - ram_rdata;
  assign hit  = sv_r && (sheld_r || (sfade_r && (el_s < 32'(rkl_pkg::FADE_TIME_MS))));

  always_comb begin
    state_nxt = state_r;
    poll_fire = 1'b0;
    poll_act  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (q_item.op == rkl_pkg::MODE_RENDER && cfg.count != 6'd0) begin
            state_nxt = ST_WALK;
          end else if (q_item.op == rkl_pkg::MODE_POLL) begin
            if (cfg.effect == rkl_pkg::EFFECT_REACT) begin
              state_nxt = ST_SCAN;
            end else begin
              poll_fire = 1'b1;
              poll_act  = (cfg.effect == rkl_pkg::EFFECT_STATIC);
            end
          end
        end
      end
      ST_WALK: begin
        if (a_nxt.last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_r == SCAN_END) begin
          state_nxt = ST_PEND;
        end
      end
      ST_PEND: begin
        poll_fire = 1'b1;
        poll_act  = act_r | hit;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      held_r   <= '0;
      fading_r <= '0;
      sv_r     <= 1'b0;
      act_r    <= 1'b0;
      a_r      <= '0;
      b_r      <= '0;
      c_r      <= '0;
      d_r      <= '0;
      e_r      <= '0;
      f_r      <= '0;
      g_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= b_r;
      d_r <= c_r;
      e_r <= d_r;
      f_r <= e_r;
      g_r <= f_r;
      sv_r <= (state_r == ST_SCAN);
      if (take) begin
        act_r <= 1'b0;
      end else if (hit) begin
        act_r <= 1'b1;
      end
      if (take && q_item.op == rkl_pkg::MODE_PRESS) begin
        held_r[k_idx]   <= 1'b1;
        fading_r[k_idx] <= 1'b0;
      end else if (ram_we) begin
        held_r[k_idx]   <= 1'b0;
        fading_r[k_idx] <= 1'b1;
      end else if (clear_fade) begin
        fading_r[IDX_W'(e_r.idx)] <= 1'b0;
      end
      out_strobe_r <= g_r.vld | poll_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      now_r  <= q_item.now;
      nl_r   <= q_item.lock_led;
      pix_r  <= 5'd0;
      scan_r <= IDX_W'(1);
    end else begin
      if (state_r == ST_WALK) begin
        pix_r <= pix_r + 5'd1;
      end
      if (state_r == ST_SCAN) begin
        scan_r <= scan_r + IDX_W'(1);
      end
    end
    if (state_r == ST_SCAN) begin
      sheld_r <= held_r[scan_r];
      sfade_r <= fading_r[scan_r];
    end
    el_r     <= el_a[15:0];
    x_c_r    <= x_c_nxt;
    p_d_r    <= p_nxt;
    x_d_r    <= x_c_r;
    q0_e_r   <= q0_nxt;
    chk_e_r  <= chk_nxt;
    x_e_r    <= x_d_r;
    pct_f_r  <= f_nxt_pct(e_r.ovl, cfg.nl_pct, pct_react);
    prod_r_r <= 15'(col_r) * 15'(pct_f_r);
    prod_g_r <= 15'(col_g) * 15'(pct_f_r);
    prod_b_r <= 15'(col_b) * 15'(pct_f_r);
    if (g_r.vld) begin
      out_idx_r   <= g_r.idx;
      out_red_r   <= m_r[rkl_pkg::DIV100_SH+7:rkl_pkg::DIV100_SH];
      out_green_r <= m_g[rkl_pkg::DIV100_SH+7:rkl_pkg::DIV100_SH];
      out_blue_r  <= m_b[rkl_pkg::DIV100_SH+7:rkl_pkg::DIV100_SH];
      out_last_r  <= g_r.last;
      out_act_r   <= 1'b0;
    end else begin
      out_idx_r   <= 5'd0;
      out_red_r   <= 8'd0;
      out_green_r <= 8'd0;
      out_blue_r  <= 8'd0;
      out_last_r  <= 1'b1;
      out_act_r   <= poll_act;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_pixel_index = out_idx_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_last        = out_last_r;
  assign out_any_active  = out_act_r;

endmodule

### design/reactive_key_led_fade_renderer_unit.sv
// top level of the reactive key backlight renderer
// depends on rkl_pkg, rkl_regs, rkl_front, rkl_back (and rkl_ram below it)
//
// Items are taken while busy is low; a two-entry queue sits in front of the engine, so busy
// rises only when two items wait. Key press and release items give no result. A render of n
// pixels (n = the pixel count register, at most 32) issues one pixel per cycle into an
// eight-stage pipeline (release time ram read, fade divide, colour scaling), and the next
// item starts only once the pipeline has drained; results come out one per cycle on
// out_strobe, pixel 0 first. A poll scans the key state one index per cycle through the
// release time ram and answers once the scan ends (without a scan outside reactive mode). Each
// result is on the out_ ports for exactly one cycle and must be taken then: the receiver
// cannot stall it. Configuration goes through the apb port, writes only while no item is in
// flight.
module reactive_key_led_fade_renderer_unit #(
  parameter int LED_NUM = rkl_pkg::LED_NUM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [4:0]  in_key_index,
  input  logic [31:0] in_now_ms,
  input  logic        in_lock_led,
  output logic        out_strobe,
  output logic [4:0]  out_pixel_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last,
  output logic        out_any_active,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rkl_pkg::cfg_t  cfg;
  rkl_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  rkl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rkl_front #(
    .LED_NUM (LED_NUM)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_key_index (in_key_index),
    .in_now_ms    (in_now_ms),
    .in_lock_led  (in_lock_led),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  rkl_back #(
    .LED_NUM (LED_NUM)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_strobe      (out_strobe),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last        (out_last),
    .out_any_active  (out_any_active)
  );

endmodule
